[design/shc_pkg.sv]
// ----------------------------------------------------------------------------
// shc_pkg: shared types and constants for the saturating health counters
// Holds op codes, report byte positions, the clamp unit request type and the
// control bundle that the sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package shc_pkg;

   localparam int DEF_COUNTER_SLOTS = 8;
   localparam int DEF_REPORT_BYTES  = 24;
   localparam int BYTE_INDEX_W      = 5;

   localparam logic [15:0] CTR_MAX        = 16'hFFFF;
   localparam logic [7:0]  MARK_MAX       = 8'hFF;
   localparam logic [7:0]  REPORT_VERSION = 8'h01;

   // Op codes of an input item.
   localparam logic [1:0] OP_EVENT = 2'd0;
   localparam logic [1:0] OP_DEPTH = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Depth mark selectors.
   localparam logic [1:0] SEL_TX    = 2'd0;
   localparam logic [1:0] SEL_EVENT = 2'd1;

   // Fixed byte positions in the report.
   localparam logic [BYTE_INDEX_W-1:0] POS_VERSION  = 5'd0;
   localparam logic [BYTE_INDEX_W-1:0] POS_FLAG     = 5'd1;
   localparam logic [BYTE_INDEX_W-1:0] POS_TX_MARK  = 5'd4;
   localparam logic [BYTE_INDEX_W-1:0] POS_EV_MARK  = 5'd5;
   localparam logic [BYTE_INDEX_W-1:0] POS_OVF_LO   = 5'd6;
   localparam logic [BYTE_INDEX_W-1:0] POS_OVF_HI   = 5'd7;
   localparam logic [BYTE_INDEX_W-1:0] POS_SLOTS_HI = 5'd8;
   localparam logic [BYTE_INDEX_W-1:0] POS_PAD_LO   = 5'd22;
   localparam logic [BYTE_INDEX_W-1:0] POS_PAD_HI   = 5'd23;

   // Word position of counter 1 is 4, so slot = word - 3 from byte 8 onward.
   localparam logic [3:0] SLOT_WORD_BASE = 4'd3;

   // Request to the shared clamp unit: result = max(floor, min(value, limit)).
   typedef struct packed {
      logic [31:0] value;
      logic        wide;    // limit 65535 when set, 255 otherwise
      logic [7:0]  floor;
   } clamp_req_type;

   // Control bundle from the sequencer.
   typedef struct packed {
      logic                    busy;
      logic                    do_update;
      logic                    do_byte;
      logic [BYTE_INDEX_W-1:0] byte_idx;
      logic                    last;
   } seq_ctl_type;

endpackage

[design/shc_clamp_unit.sv]
// ----------------------------------------------------------------------------
// shc_clamp_unit: shared saturate and raise unit
// Clamps a value to 255 or 65535, flags when clamping happened, and raises
// the clamped value to a floor. Serves counter bumps, marks and report bytes.
// ----------------------------------------------------------------------------
module shc_clamp_unit
   import shc_pkg::*;
(
   input  clamp_req_type req,
   output logic [15:0]   result,
   output logic          over
);

   logic [15:0] limit;
   logic [15:0] clamped;
   logic [15:0] floor_w;

   always_comb begin
      limit   = req.wide ? CTR_MAX : {8'd0, MARK_MAX};
      over    = req.value > {16'd0, limit};
      clamped = over ? limit : req.value[15:0];
      floor_w = {8'd0, req.floor};
      result  = (clamped > floor_w) ? clamped : floor_w;
   end

endmodule

[design/shc_seq.sv]
// ----------------------------------------------------------------------------
// shc_seq: operation sequencer
// Runs the update state for event and depth items and walks the report byte
// by byte, advancing only when the output register can take a byte.
// ----------------------------------------------------------------------------
module shc_seq
   import shc_pkg::*;
#(
   parameter int REPORT_BYTES = DEF_REPORT_BYTES
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  op,
   input  logic        out_free,
   output seq_ctl_type ctl
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_UPDATE = 3'b010,
      ST_REPORT = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [BYTE_INDEX_W-1:0] cnt_ff, cnt_in;
   logic                    last;

   assign last = (cnt_ff == BYTE_INDEX_W'(REPORT_BYTES - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (op == OP_READ) begin
                  state_in = ST_REPORT;
                  cnt_in   = '0;
               end else if (op == OP_EVENT || op == OP_DEPTH) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         ST_REPORT: begin
            if (out_free) begin
               if (last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      ctl.busy      = (state_ff != ST_IDLE);
      ctl.do_update = (state_ff == ST_UPDATE);
      ctl.do_byte   = (state_ff == ST_REPORT) && out_free;
      ctl.byte_idx  = cnt_ff;
      ctl.last      = last;
   end

endmodule

[design/saturating_health_counters.sv]
// ----------------------------------------------------------------------------
// saturating_health_counters: saturating event counters and health report
// An event or depth item is applied in the update state, in the cycle after
// it is accepted; req_stall stays high until then, so the next item waits.
// A read item walks the report through the sequencer's report state into the
// output register, one byte per cycle while rsp_stall is low.
// Reset clears all counters, both marks, the saturation flag and rsp_valid.
// ----------------------------------------------------------------------------
module saturating_health_counters
   import shc_pkg::*;
#(
   parameter int COUNTER_SLOTS = DEF_COUNTER_SLOTS,
   parameter int REPORT_BYTES  = DEF_REPORT_BYTES
)
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_counter_index,
   input  logic [1:0]  req_depth_which,
   input  logic [31:0] req_depth_used,
   input  logic        req_stats_present,
   input  logic [31:0] req_stats_overflow_marks,
   input  logic [31:0] req_stats_high_water,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_byte_index,
   output logic [7:0]  rsp_byte_value,
   output logic        rsp_last
);

   // Index width of the counter array; a single slot still uses one bit.
   localparam int IDX_W = (COUNTER_SLOTS > 1) ? $clog2(COUNTER_SLOTS) : 1;

   // The whole block is a single shared clamp unit driven by a small
   // sequencer. Every cycle the sequencer chooses what the unit works on:
   // a counter bump, a depth mark update, or one byte of the report.

   seq_ctl_type   ctl;
   clamp_req_type unit_req;
   logic [15:0]   unit_result;
   logic          unit_over;

   logic          accept;
   logic          out_free;

   // Item payload, captured when the item is accepted.
   logic [1:0]    op_ff;
   logic [3:0]    idx_ff;
   logic [1:0]    which_ff;
   logic [31:0]   used_ff;
   logic          present_ff;
   logic [31:0]   ovf_ff;
   logic [31:0]   hw_ff;

   // Architectural state.
   logic [15:0]   counts_ff [COUNTER_SLOTS];
   logic [15:0]   counts_in [COUNTER_SLOTS];
   logic [7:0]    tx_mark_ff, tx_mark_in;
   logic [7:0]    ev_mark_ff, ev_mark_in;
   logic          flag_ff, flag_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BYTE_INDEX_W-1:0] rsp_index_ff;
   logic [7:0]              rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff;

   // Counter lookups for the event update and for the report walk.
   logic                    evt_slot_ok;
   logic [15:0]             evt_count;
   logic [3:0]              rpt_slot;
   logic                    rpt_slot_ok;
   logic [15:0]             rpt_count;
   logic [BYTE_INDEX_W-1:0] k;

   assign accept    = req_valid && !ctl.busy;
   assign req_stall = ctl.busy;
   // The output register can take a byte when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   shc_seq #(
      .REPORT_BYTES(REPORT_BYTES)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .op       (req_op),
      .out_free (out_free),
      .ctl      (ctl)
   );

   shc_clamp_unit u_clamp (
      .req    (unit_req),
      .result (unit_result),
      .over   (unit_over)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_op;
         idx_ff     <= req_counter_index;
         which_ff   <= req_depth_which;
         used_ff    <= req_depth_used;
         present_ff <= req_stats_present;
         ovf_ff     <= req_stats_overflow_marks;
         hw_ff      <= req_stats_high_water;
      end
   end

   assign k = ctl.byte_idx;

   always_comb begin
      evt_slot_ok = ({1'b0, idx_ff} < 5'(COUNTER_SLOTS));
      evt_count   = evt_slot_ok ? counts_ff[idx_ff[IDX_W-1:0]] : 16'd0;

      // Bytes 2 and 3 carry counter 0; from byte 8 on each word is one slot.
      if (k < POS_SLOTS_HI) begin
         rpt_slot = 4'd0;
      end else begin
         rpt_slot = k[4:1] - SLOT_WORD_BASE;
      end
      rpt_slot_ok = ({1'b0, rpt_slot} < 5'(COUNTER_SLOTS));
      rpt_count   = rpt_slot_ok ? counts_ff[rpt_slot[IDX_W-1:0]] : 16'd0;
   end

   // Work for the shared unit. An event bump clamps count + 1 against 65535,
   // so a counter already at the top stays there and reports an overflow.
   // A depth note clamps to 255 and uses the current mark as the floor,
   // which makes the result the raised mark.
   always_comb begin
      unit_req.value = 32'd0;
      unit_req.wide  = 1'b1;
      unit_req.floor = 8'd0;
      if (ctl.do_update) begin
         if (op_ff == OP_EVENT) begin
            unit_req.value = {15'd0, ({1'b0, evt_count} + 17'd1)};
         end else begin
            unit_req.value = used_ff;
            unit_req.wide  = 1'b0;
            unit_req.floor = (which_ff == SEL_TX) ? tx_mark_ff : ev_mark_ff;
         end
      end else begin
         case (k)
            POS_EV_MARK: begin
               // Reported event mark merges the external high water.
               unit_req.value = present_ff ? hw_ff : 32'd0;
               unit_req.wide  = 1'b0;
               unit_req.floor = ev_mark_ff;
            end
            POS_OVF_LO, POS_OVF_HI: begin
               unit_req.value = present_ff ? ovf_ff : 32'd0;
            end
            default: begin
               unit_req.value = {16'd0, rpt_count};
            end
         endcase
      end
   end

   // State updates.
   always_comb begin
      counts_in  = counts_ff;
      tx_mark_in = tx_mark_ff;
      ev_mark_in = ev_mark_ff;
      flag_in    = flag_ff;

      if (ctl.do_update) begin
         case (op_ff)
            OP_EVENT: begin
               if (evt_slot_ok) begin
                  counts_in[idx_ff[IDX_W-1:0]] = unit_result;
                  if (unit_over) begin
                     flag_in = 1'b1;
                  end
               end
            end
            OP_DEPTH: begin
               case (which_ff)
                  SEL_TX:    tx_mark_in = unit_result[7:0];
                  SEL_EVENT: ev_mark_in = unit_result[7:0];
                  default:   ;
               endcase
            end
            default: ;
         endcase
      end

      // A clamped overflow count marks the flag for later reads only; the
      // flag byte has already gone out by the time the overflow word is built.
      if (ctl.do_byte && (k == POS_OVF_LO || k == POS_OVF_HI) && unit_over) begin
         flag_in = 1'b1;
      end
   end

   // Report byte selection.
   always_comb begin
      case (k)
         POS_VERSION:            rsp_value_in = REPORT_VERSION;
         POS_FLAG:               rsp_value_in = {7'd0, flag_ff};
         POS_TX_MARK:            rsp_value_in = tx_mark_ff;
         POS_EV_MARK:            rsp_value_in = unit_result[7:0];
         POS_PAD_LO, POS_PAD_HI: rsp_value_in = 8'd0;
         default: begin
            // Little-endian words: low byte at even positions.
            rsp_value_in = k[0] ? unit_result[15:8] : unit_result[7:0];
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.do_byte) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COUNTER_SLOTS; i++) begin
            counts_ff[i] <= 16'd0;
         end
         tx_mark_ff   <= 8'd0;
         ev_mark_ff   <= 8'd0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         counts_ff    <= counts_in;
         tx_mark_ff   <= tx_mark_in;
         ev_mark_ff   <= ev_mark_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.do_byte) begin
         rsp_index_ff <= k;
         rsp_value_ff <= rsp_value_in;
         rsp_last_ff  <= ctl.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_byte_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

   // The final byte of a report always sits at the last report position.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_index_ff == BYTE_INDEX_W'(REPORT_BYTES - 1)))
      else $error("last flag on a byte that is not the final report position");

   // Once the final byte is loaded the sequencer is free for a new item.
   assert property (@(posedge clock) disable iff (reset)
      (ctl.do_byte && ctl.last) |=> !ctl.busy)
      else $error("sequencer still busy after the final report byte");

   // Every byte step leaves a valid byte in the output register.
   assert property (@(posedge clock) disable iff (reset)
      ctl.do_byte |=> rsp_valid_ff)
      else $error("report byte step lost its byte");

   // The saturation flag is sticky.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(flag_ff)) |-> flag_ff)
      else $error("saturation flag cleared outside reset");

   // High-water marks never fall.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (tx_mark_ff >= $past(tx_mark_ff) && ev_mark_ff >= $past(ev_mark_ff)))
      else $error("a high-water mark decreased");

endmodule

[tb/tb_saturating_health_counters.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_saturating_health_counters: self-checking bench for the health counters
// Feeds event, depth, read and unknown-op items through the request channel
// and predicts every report byte from its own copy of the counters, the marks
// and the sticky flag. It checks each byte against the oldest prediction and
// runs three phases, the first two with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_saturating_health_counters;
   import shc_pkg::*;

   // Op 3 has no meaning in the block; it must be swallowed without a report.
   localparam logic [1:0] OP_NONE     = 2'd3;
   // Cycles with no handshake on either channel before the run is abandoned.
   localparam int         QUIET_LIMIT = 2000;
   // Cycles to keep watching for stray bytes once everything has arrived.
   localparam int         TAIL_CYCLES = 40;

   // One request item as the bench queues it. drain_first makes the driver
   // hold the item back until every outstanding report byte has come out.
   typedef struct {
      logic [1:0]  op;
      logic [3:0]  slot;
      logic [1:0]  which;
      logic [31:0] used;
      logic        present;
      logic [31:0] ovf;
      logic [31:0] hw;
      bit          drain_first;
   } health_req_type;

   // One predicted report byte.
   typedef struct {
      logic [4:0] index;
      logic [7:0] value;
      logic       is_last;
   } report_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_NONE;
   logic [3:0]  req_counter_index = '0;
   logic [1:0]  req_depth_which = '0;
   logic [31:0] req_depth_used = '0;
   logic        req_stats_present = 1'b0;
   logic [31:0] req_stats_overflow_marks = '0;
   logic [31:0] req_stats_high_water = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_byte_index;
   logic [7:0]  rsp_byte_value;
   logic        rsp_last;

   saturating_health_counters DUT (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_op                   (req_op),
      .req_counter_index        (req_counter_index),
      .req_depth_which          (req_depth_which),
      .req_depth_used           (req_depth_used),
      .req_stats_present        (req_stats_present),
      .req_stats_overflow_marks (req_stats_overflow_marks),
      .req_stats_high_water     (req_stats_high_water),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_byte_index           (rsp_byte_index),
      .rsp_byte_value           (rsp_byte_value),
      .rsp_last                 (rsp_last)
   );

   always #2 clock = ~clock;

   // Shadow of the block's state. Reset is applied once at time zero, so the
   // declaration values are the reset values.
   logic [15:0] shadow_counts [DEF_COUNTER_SLOTS] = '{default: '0};
   logic [7:0]  shadow_tx_mark = '0;
   logic [7:0]  shadow_ev_mark = '0;
   logic        shadow_flag = 1'b0;

   health_req_type  pending_reqs [$];   // items not yet presented to the block
   report_byte_type report_q [$];       // predicted bytes not yet seen
   health_req_type  cur_req;            // item currently on the request ports
   health_req_type  next_req;
   report_byte_type want_byte;

   int send_idle_pct  = 23;
   int recv_stall_pct = 69;
   int items_queued   = 0;   // written by the stimulus process only
   int items_taken    = 0;   // these counters, mismatches apart, are updated nonblocking
   int bytes_due      = 0;
   int bytes_checked  = 0;
   int reads_taken    = 0;
   int quiet_cycles   = 0;
   int mismatches     = 0;

   // Every mismatch goes through here: one line each, and a running count
   // that the verdict looks at.
   task automatic note_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
   endtask

   // Applies one accepted item to the shadow state and, for a read, appends
   // the 24 report bytes it must produce. The flag byte is taken before the
   // overflow clamp, because the clamp only shows up in later reads. The
   // external high water is merged into the event mark byte only; the stored
   // mark does not move.
   task automatic predict_health(input health_req_type r);
      logic [7:0]      rep [DEF_REPORT_BYTES];
      logic [15:0]     ovf_sent;
      logic [7:0]      depth_val;
      report_byte_type b;

      case (r.op)
         OP_EVENT: begin
            // Slots past the end are dropped without any effect.
            if (r.slot < DEF_COUNTER_SLOTS) begin
               if (shadow_counts[r.slot] == CTR_MAX)
                  shadow_flag = 1'b1;
               else
                  shadow_counts[r.slot] = shadow_counts[r.slot] + 16'd1;
            end
         end
         OP_DEPTH: begin
            depth_val = (r.used > MARK_MAX) ? MARK_MAX : r.used[7:0];
            if (r.which == SEL_TX && depth_val > shadow_tx_mark)
               shadow_tx_mark = depth_val;
            else if (r.which == SEL_EVENT && depth_val > shadow_ev_mark)
               shadow_ev_mark = depth_val;
         end
         OP_READ: begin
            foreach (rep[k])
               rep[k] = 8'h00;
            rep[POS_VERSION] = REPORT_VERSION;
            rep[POS_FLAG]    = {7'b0, shadow_flag};
            rep[2]           = shadow_counts[0][7:0];
            rep[3]           = shadow_counts[0][15:8];
            rep[POS_TX_MARK] = shadow_tx_mark;
            rep[POS_EV_MARK] = shadow_ev_mark;
            if (r.present && r.hw > shadow_ev_mark)
               rep[POS_EV_MARK] = (r.hw > MARK_MAX) ? MARK_MAX : r.hw[7:0];
            // Without external statistics the overflow count reads as zero.
            ovf_sent = 16'h0000;
            if (r.present) begin
               if (r.ovf > CTR_MAX) begin
                  ovf_sent    = CTR_MAX;
                  shadow_flag = 1'b1;
               end else begin
                  ovf_sent = r.ovf[15:0];
               end
            end
            rep[POS_OVF_LO] = ovf_sent[7:0];
            rep[POS_OVF_HI] = ovf_sent[15:8];
            // Counters 1..7 fill bytes 8..21; bytes 22 and 23 stay zero.
            for (int k = 1; k < 8; k++) begin
               rep[POS_SLOTS_HI + 2 * (k - 1)]     = shadow_counts[k][7:0];
               rep[POS_SLOTS_HI + 2 * (k - 1) + 1] = shadow_counts[k][15:8];
            end
            for (int k = 0; k < DEF_REPORT_BYTES; k++) begin
               b.index   = k[4:0];
               b.value   = rep[k];
               b.is_last = (k == DEF_REPORT_BYTES - 1);
               report_q.push_back(b);
            end
         end
         default: ;   // an unknown op leaves everything alone
      endcase
   endtask

   // Driver. A new item is loaded only when the slot is free, that is when
   // nothing is on the ports or the current item is being taken at this edge.
   // An item marked drain_first waits until the report queue is empty; if
   // something was taken at this very edge, its bytes are not counted yet,
   // so the driver also waits while any item is still on the ports.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() != 0 &&
             !(pending_reqs[0].drain_first && (req_valid || bytes_due != 0)) &&
             $urandom_range(99) >= send_idle_pct) begin
            next_req = pending_reqs.pop_front();
            cur_req                  <= next_req;
            req_op                   <= next_req.op;
            req_counter_index        <= next_req.slot;
            req_depth_which          <= next_req.which;
            req_depth_used           <= next_req.used;
            req_stats_present        <= next_req.present;
            req_stats_overflow_marks <= next_req.ovf;
            req_stats_high_water     <= next_req.hw;
            req_valid                <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure; it is free to change on every cycle.
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Monitor. Report bytes are checked before the item taken at the same edge
   // is predicted, since a byte can never belong to an item that is only now
   // being accepted. The counters it exports are written nonblocking so that
   // the driver and the stimulus process read settled values.
   always @(posedge clock) begin
      if (reset) begin
         items_taken   <= 0;
         bytes_due     <= 0;
         bytes_checked <= 0;
         reads_taken   <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (report_q.size() == 0) begin
               note_mismatch("report byte with no read outstanding, index",
                             int'(rsp_byte_index), -1);
            end else begin
               want_byte = report_q.pop_front();
               if (rsp_byte_index !== want_byte.index)
                  note_mismatch("byte_index", int'(rsp_byte_index),
                                int'(want_byte.index));
               if (rsp_byte_value !== want_byte.value)
                  note_mismatch($sformatf("byte_value at index %0d", want_byte.index),
                                int'(rsp_byte_value), int'(want_byte.value));
               if (rsp_last !== want_byte.is_last)
                  note_mismatch($sformatf("last at index %0d", want_byte.index),
                                int'(rsp_last), int'(want_byte.is_last));
            end
            bytes_checked <= bytes_checked + 1;
         end
         if (req_valid && !req_stall) begin
            predict_health(cur_req);
            items_taken <= items_taken + 1;
            if (cur_req.op == OP_READ)
               reads_taken <= reads_taken + 1;
         end
         bytes_due <= report_q.size();
      end
   end

   // Watchdog on handshakes: a hang on either side stops the run here.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("No handshake for %0d cycles, %0d bytes still due, giving up.",
                  QUIET_LIMIT, bytes_due);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_req(input logic [1:0] op, input logic [3:0] slot,
                            input logic [1:0] which, input logic [31:0] used,
                            input logic present, input logic [31:0] ovf,
                            input logic [31:0] hw);
      health_req_type r;
      r.op          = op;
      r.slot        = slot;
      r.which       = which;
      r.used        = used;
      r.present     = present;
      r.ovf         = ovf;
      r.hw          = hw;
      r.drain_first = 1'b0;
      pending_reqs.push_back(r);
      items_queued++;
   endtask

   // Random items. Every field is filled on every item, whatever the op, so
   // the ignored fields toggle too. Small depths keep the marks climbing
   // slowly so the high-water merge stays interesting; full-range depths are
   // only allowed when wide_depth is set, since they pin the marks at 255.
   // The first item of each batch, and a few others, wait for a full drain.
   task automatic queue_random(input int count, input bit wide_depth);
      health_req_type r;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 40)      r.op = OP_EVENT;
         else if (pick < 65) r.op = OP_DEPTH;
         else if (pick < 93) r.op = OP_READ;
         else                r.op = OP_NONE;
         r.slot  = ($urandom_range(3) != 0) ? 4'($urandom_range(7))
                                            : 4'($urandom_range(15, 8));
         r.which = 2'($urandom_range(3));
         if (wide_depth && $urandom_range(1))
            r.used = $urandom;
         else
            r.used = $urandom_range(n / 2 + 20);
         r.present = 1'($urandom_range(1));
         case ($urandom_range(2))
            0:       r.ovf = $urandom_range(300);
            1:       r.ovf = $urandom_range(70000, 60000);
            default: r.ovf = $urandom;
         endcase
         r.hw = $urandom_range(1) ? $urandom_range(300) : $urandom;
         r.drain_first = (n == 0) || ($urandom_range(99) < 3);
         pending_reqs.push_back(r);
         items_queued++;
      end
   endtask

   // Stimulus and verdict. After reset everything runs on the falling edge so
   // it never races the clocked blocks above.
   initial begin
      // Read straight out of reset; stats absent, so the huge external
      // figures must not leak into the report.
      queue_req(OP_READ, 4'd0, 2'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // First and last slot, then two indices past the end.
      queue_req(OP_EVENT, 4'd0, 2'd0, 32'd0, 1'b0, 32'd0, 32'd0);
      queue_req(OP_EVENT, 4'd7, 2'd0, 32'd0, 1'b0, 32'd0, 32'd0);
      queue_req(OP_EVENT, 4'd8, 2'd0, 32'd0, 1'b0, 32'd0, 32'd0);
      queue_req(OP_EVENT, 4'd15, 2'd0, 32'd0, 1'b0, 32'd0, 32'd0);
      // Both marks, both unknown selectors, and a smaller depth that must
      // not lower the transmit mark.
      queue_req(OP_DEPTH, 4'd0, SEL_TX, 32'd5, 1'b0, 32'd0, 32'd0);
      queue_req(OP_DEPTH, 4'd0, SEL_EVENT, 32'd7, 1'b0, 32'd0, 32'd0);
      queue_req(OP_DEPTH, 4'd0, 2'd2, 32'd100, 1'b0, 32'd0, 32'd0);
      queue_req(OP_DEPTH, 4'd0, 2'd3, 32'd200, 1'b0, 32'd0, 32'd0);
      queue_req(OP_DEPTH, 4'd0, SEL_TX, 32'd3, 1'b0, 32'd0, 32'd0);
      queue_req(OP_NONE, 4'd1, 2'd1, 32'd9, 1'b1, 32'd9, 32'd9);
      // External high water above, far above and below the stored mark;
      // overflow counts below and exactly at the clamp.
      queue_req(OP_READ, 4'd0, 2'd0, 32'd0, 1'b1, 32'h0000_1234, 32'd200);
      queue_req(OP_READ, 4'd0, 2'd0, 32'd0, 1'b1, 32'h0000_FFFF, 32'hFFFF_FFFF);
      queue_req(OP_READ, 4'd0, 2'd0, 32'd0, 1'b1, 32'd0, 32'd3);
      // Depths beyond 255 clamp the marks.
      queue_req(OP_DEPTH, 4'd0, SEL_EVENT, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0);
      queue_req(OP_DEPTH, 4'd0, SEL_TX, 32'h0000_0100, 1'b0, 32'd0, 32'd0);
      // Overflow counts just past and far past the clamp; the first sets the
      // flag, which the second read must then report.
      queue_req(OP_READ, 4'd0, 2'd0, 32'd0, 1'b1, 32'h0001_0000, 32'd0);
      queue_req(OP_READ, 4'd0, 2'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'd0);
      queue_req(OP_READ, 4'd0, 2'd0, 32'd0, 1'b0, 32'd0, 32'd0);
      queue_req(OP_EVENT, 4'd2, 2'd0, 32'd0, 1'b0, 32'd0, 32'd0);
      queue_random(120, 1'b0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Second phase: a slow sender against a mostly ready receiver.
      while (items_taken != items_queued) @(negedge clock);
      send_idle_pct  = 69;
      recv_stall_pct = 23;
      queue_random(120, 1'b0);

      // Last phase: no idling anywhere, full-range depths allowed.
      while (items_taken != items_queued) @(negedge clock);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_random(110, 1'b1);

      while (items_taken != items_queued || bytes_due != 0) @(negedge clock);
      // Stray bytes would show up well before this tail runs out.
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d items, %0d of them report reads, and checked %0d report bytes.",
               items_taken, reads_taken, bytes_checked);
      $display("Covered idle gaps, ignored selectors and ops, mark and overflow clamps "
               , "and the sticky flag seen by later reads.");
      if (mismatches == 0 && bytes_due == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d bytes still due.", mismatches, bytes_due);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[saturating_health_counters.f]
design/shc_pkg.sv
design/shc_clamp_unit.sv
design/shc_seq.sv
design/saturating_health_counters.sv
tb/tb_saturating_health_counters.sv
